[hw/rtl/sfr_pkg.sv]
// Shared types and codes of the serial frame receiver.
package sfr_pkg;

	// Result word kinds
	typedef enum logic [1:0] {
		EV_PAYLOAD = 2'd0,
		EV_GOOD    = 2'd1,
		EV_BAD     = 2'd2,
		EV_LENERR  = 2'd3
	} event_kind_t;

	// Configuration register indexes
	localparam logic REG_START_BYTE = 1'b0;
	localparam logic REG_TOKEN_BYTE = 1'b1;

	localparam logic [7:0] START_BYTE_RST = 8'd27;
	localparam logic [7:0] TOKEN_BYTE_RST = 8'd14;

	// Result of one parse step
	typedef struct packed {
		logic        emit;
		event_kind_t kind;
		logic [7:0]  payload_byte;
		logic [11:0] payload_index;
		logic [7:0]  frame_seq;
		logic [15:0] frame_length;
	} sfr_result_t;

endpackage

[hw/rtl/serial_frame_receiver_core.sv]
// Serial frame receiver top level: input register, parser and result register.
// Takes one received byte per word and reports payload bytes, checksum
// verdicts and length errors of framed packets (start byte, sequence number,
// 16-bit big-endian length, token byte, payload, XOR checksum). One byte is
// accepted every cycle unless the input register is stalled; each byte is
// held in the input register and its result, if any, is loaded from there
// into the output register. The only throughput limit is the output register:
// a result word held by a stalled consumer blocks the byte behind it once
// that byte also produces a result. start_byte and token_byte are written
// through the configuration channel, which is always ready.
module serial_frame_receiver_core #(
	parameter int MAX_PAYLOAD = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_kind,
	output logic [7:0]  payload_byte,
	output logic [11:0] payload_index,
	output logic [7:0]  frame_seq,
	output logic [15:0] frame_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0]          start_byte_q;
	logic [7:0]          token_byte_q;
	logic                valid_s1;
	logic [7:0]          rx_byte_s1;
	sfr_pkg::sfr_result_t result;
	sfr_pkg::sfr_result_t res_q;
	logic                out_valid_q;
	logic                stall;
	logic                advance;
	logic                load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= sfr_pkg::START_BYTE_RST;
			token_byte_q <= sfr_pkg::TOKEN_BYTE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sfr_pkg::REG_START_BYTE: start_byte_q <= cfg_data;
				sfr_pkg::REG_TOKEN_BYTE: token_byte_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// hold the byte only when its result cannot enter the output register
	assign stall    = valid_s1 && result.emit && out_valid_q && !out_ready;
	assign advance  = valid_s1 && !stall;
	assign load     = advance && result.emit;
	assign in_ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	sfr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte    (rx_byte_s1),
		.start_byte (start_byte_q),
		.token_byte (token_byte_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = res_q.kind;
	assign payload_byte  = res_q.payload_byte;
	assign payload_index = res_q.payload_index;
	assign frame_seq     = res_q.frame_seq;
	assign frame_length  = res_q.frame_length;

endmodule

[hw/rtl/sfr_parser.sv]
// Frame parse state machine: header checks, payload indexing and checksum verdict.
module sfr_parser #(
	parameter int MAX_PAYLOAD = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          start_byte,
	input  logic [7:0]          token_byte,
	output sfr_pkg::sfr_result_t result
);

	localparam int CntBits = $clog2(MAX_PAYLOAD + 1);
	localparam int CntW = (CntBits > 12) ? CntBits : 12;
	localparam logic [16:0] MaxLen = 17'(MAX_PAYLOAD);

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_SEQ   = 3'd1,
		PH_LEN1  = 3'd2,
		PH_LEN2  = 3'd3,
		PH_TOKEN = 3'd4,
		PH_DATA  = 3'd5,
		PH_CHECK = 3'd6
	} phase_t;

	phase_t           phase_q;
	logic [7:0]       xor_q;
	logic [7:0]       exp_seq_q;
	logic [15:0]      length_q;
	logic [CntW-1:0]  count_q;

	logic [15:0]      len_full;
	logic             len_bad;
	logic [CntW-1:0]  count_inc;
	logic             last_byte;
	logic             seq_ok;
	logic             sum_ok;

	assign len_full  = {length_q[15:8], rx_byte};
	assign len_bad   = (len_full == 16'd0) || ({1'b0, len_full} > MaxLen);
	assign count_inc = count_q + 1'b1;
	assign last_byte = 17'(count_inc) >= {1'b0, length_q};
	assign seq_ok    = (rx_byte == 8'd1) || (rx_byte == exp_seq_q);
	assign sum_ok    = (rx_byte == xor_q);

	always_comb begin
		result = '0;
		result.frame_seq    = exp_seq_q;
		result.frame_length = length_q;
		unique case (phase_q)
			PH_LEN2: begin
				result.frame_length = len_full;
				if (len_bad) begin
					result.emit = 1'b1;
					result.kind = sfr_pkg::EV_LENERR;
				end
			end
			PH_DATA: begin
				result.emit          = 1'b1;
				result.kind          = sfr_pkg::EV_PAYLOAD;
				result.payload_byte  = rx_byte;
				result.payload_index = count_q[11:0];
			end
			PH_CHECK: begin
				result.emit = 1'b1;
				result.kind = sum_ok ? sfr_pkg::EV_GOOD : sfr_pkg::EV_BAD;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			xor_q     <= 8'd0;
			exp_seq_q <= 8'd0;
			length_q  <= 16'd0;
			count_q   <= '0;
		end else if (step) begin
			unique case (phase_q)
				PH_START: begin
					if (rx_byte == start_byte) begin
						xor_q   <= rx_byte;
						phase_q <= PH_SEQ;
					end
				end
				PH_SEQ: begin
					// a rejected sequence byte is dropped, not rechecked as start
					if (seq_ok) begin
						exp_seq_q <= rx_byte;
						xor_q     <= xor_q ^ rx_byte;
						phase_q   <= PH_LEN1;
					end else begin
						phase_q <= PH_START;
					end
				end
				PH_LEN1: begin
					length_q <= {rx_byte, 8'd0};
					xor_q    <= xor_q ^ rx_byte;
					phase_q  <= PH_LEN2;
				end
				PH_LEN2: begin
					length_q <= len_full;
					xor_q    <= xor_q ^ rx_byte;
					phase_q  <= len_bad ? PH_START : PH_TOKEN;
				end
				PH_TOKEN: begin
					if (rx_byte == token_byte) begin
						xor_q   <= xor_q ^ rx_byte;
						count_q <= '0;
						phase_q <= PH_DATA;
					end else begin
						phase_q <= PH_START;
					end
				end
				PH_DATA: begin
					xor_q   <= xor_q ^ rx_byte;
					count_q <= count_inc;
					if (last_byte) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					if (sum_ok) begin
						exp_seq_q <= exp_seq_q + 8'd1;
					end
					phase_q <= PH_START;
				end
				default: begin
					phase_q <= PH_START;
				end
			endcase
		end
	end

endmodule

[tb/serial_frame_receiver_core_tb.sv]
// Self-checking testbench for the serial frame receiver core.
module serial_frame_receiver_core_tb;

	localparam int MAX_LEN        = 4096;
	localparam int RANDOM_ITEMS   = 150;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 6;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int STEADY_FRAMES  = 64;

	typedef enum {
		WAIT_START, GET_SEQ, GET_LEN_HI, GET_LEN_LO, GET_TOKEN, GET_DATA, GET_CHECK
	} rx_phase_t;

	typedef enum {SEQ_KEEP, SEQ_RESTART, SEQ_ANY} seq_pick_t;

	typedef struct {
		sfr_pkg::event_kind_t kind;
		logic [7:0]  pbyte;
		logic [11:0] pindex;
		logic [7:0]  seq;
		logic [15:0] length;
	} frame_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  event_kind;
	logic [7:0]  payload_byte;
	logic [11:0] payload_index;
	logic [7:0]  frame_seq;
	logic [15:0] frame_length;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = sfr_pkg::REG_START_BYTE;
	logic [7:0]  cfg_data = 8'h00;

	// Parser mirror
	logic [7:0]  start_m = sfr_pkg::START_BYTE_RST;
	logic [7:0]  token_m = sfr_pkg::TOKEN_BYTE_RST;
	rx_phase_t   rx_phase = WAIT_START;
	logic [7:0]  run_xor = 8'h00;
	logic [7:0]  exp_seq = 8'h00;
	logic [15:0] frame_len = 16'h0000;
	logic [15:0] data_count = 16'h0000;
	frame_event_t pending_events[$];

	int errors = 0;
	int parsed_bytes = 0;
	int reg_writes = 0;
	int seen_kind[4] = '{0, 0, 0, 0};
	int quiet_cycles = 0;
	bit steady = 1'b0;
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;

	serial_frame_receiver_core #(
		.MAX_PAYLOAD(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.frame_seq(frame_seq),
		.frame_length(frame_length),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic frame_event_t event_of(input sfr_pkg::event_kind_t k,
			input logic [7:0] b, input logic [11:0] idx);
		frame_event_t ev;
		ev.kind   = k;
		ev.pbyte  = b;
		ev.pindex = idx;
		ev.seq    = exp_seq;
		ev.length = frame_len;
		return ev;
	endfunction

	// Advance the parser mirror by one accepted byte and queue its result word, if any.
	task automatic predict_byte(input logic [7:0] b);
		frame_event_t ev;
		bit hit;
		hit = 1'b0;
		if (rx_phase != WAIT_START || b == start_m)
			parsed_bytes++;
		case (rx_phase)
			WAIT_START: begin
				if (b == start_m) begin
					run_xor  = b;
					rx_phase = GET_SEQ;
				end
			end
			GET_SEQ: begin
				if (b == 8'd1 || b == exp_seq) begin
					exp_seq  = b;
					run_xor  ^= b;
					rx_phase = GET_LEN_HI;
				end else begin
					rx_phase = WAIT_START;
				end
			end
			GET_LEN_HI: begin
				frame_len = {b, 8'h00};
				run_xor   ^= b;
				rx_phase  = GET_LEN_LO;
			end
			GET_LEN_LO: begin
				frame_len[7:0] = b;
				run_xor        ^= b;
				if (frame_len == 16'd0 || frame_len > MAX_LEN) begin
					rx_phase = WAIT_START;
					ev  = event_of(sfr_pkg::EV_LENERR, 8'h00, 12'h000);
					hit = 1'b1;
				end else begin
					rx_phase = GET_TOKEN;
				end
			end
			GET_TOKEN: begin
				if (b == token_m) begin
					run_xor    ^= b;
					data_count = 16'd0;
					rx_phase   = GET_DATA;
				end else begin
					rx_phase = WAIT_START;
				end
			end
			GET_DATA: begin
				run_xor ^= b;
				ev  = event_of(sfr_pkg::EV_PAYLOAD, b, data_count[11:0]);
				hit = 1'b1;
				if (data_count + 1 >= frame_len)
					rx_phase = GET_CHECK;
				data_count = data_count + 16'd1;
			end
			GET_CHECK: begin
				rx_phase = WAIT_START;
				hit = 1'b1;
				if (b == run_xor) begin
					ev = event_of(sfr_pkg::EV_GOOD, 8'h00, 12'h000);
					exp_seq = exp_seq + 8'd1;
				end else begin
					ev = event_of(sfr_pkg::EV_BAD, 8'h00, 12'h000);
				end
			end
			default: rx_phase = WAIT_START;
		endcase
		if (hit)
			pending_events.push_back(ev);
	endtask

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		if (!steady && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		predict_byte(b);
	endtask

	// Drop valid, wait for every queued word, then let the pipeline empty.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == sfr_pkg::REG_START_BYTE)
			start_m = val;
		else
			token_m = val;
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] sb, input logic [7:0] tb);
		drain();
		write_reg(sfr_pkg::REG_START_BYTE, sb);
		write_reg(sfr_pkg::REG_TOKEN_BYTE, tb);
	endtask

	task automatic send_frame(input logic [15:0] len, input seq_pick_t pick,
			input bit bad_token, input bit bad_sum);
		logic [7:0] sum;
		logic [7:0] s;
		logic [7:0] b;
		// finish whatever frame the parser is still inside
		while (rx_phase != WAIT_START)
			send_byte(8'($urandom_range(255)));
		send_byte(start_m);
		sum = start_m;
		case (pick)
			SEQ_KEEP:    s = exp_seq;
			SEQ_RESTART: s = 8'd1;
			default:     s = 8'($urandom_range(255));
		endcase
		send_byte(s);
		if (rx_phase == WAIT_START)
			return;
		sum ^= s;
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		if (rx_phase == WAIT_START)
			return;
		sum ^= len[15:8] ^ len[7:0];
		b = bad_token ? token_m ^ 8'($urandom_range(255, 1)) : token_m;
		send_byte(b);
		if (rx_phase == WAIT_START)
			return;
		sum ^= b;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(255));
			send_byte(b);
			sum ^= b;
		end
		send_byte(bad_sum ? sum ^ 8'($urandom_range(255, 1)) : sum);
	endtask

	task automatic random_frame();
		int r;
		logic [15:0] len;
		seq_pick_t pick;
		if ($urandom_range(99) < 10)
			repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255)));
		r = $urandom_range(99);
		if (r < 60)
			len = 16'($urandom_range(8, 1));
		else if (r < 85)
			len = 16'($urandom_range(40, 9));
		else if (r < 92)
			len = 16'($urandom_range(300, 41));
		else if (r < 95)
			len = 16'd0;
		else
			len = 16'($urandom_range(65535, MAX_LEN + 1));
		r = $urandom_range(99);
		pick = (r < 70) ? SEQ_KEEP : (r < 85) ? SEQ_RESTART : SEQ_ANY;
		send_frame(len, pick, $urandom_range(99) < 5, $urandom_range(99) < 8);
	endtask

	function automatic logic [7:0] reg_pick();
		case ($urandom_range(3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// A rejected sequence byte that equals the start value must not restart the frame.
	task automatic test_header_rejects();
		send_byte(start_m);
		send_byte(start_m);
		send_byte(8'd1);
		send_byte(8'd0);
		send_byte(8'd1);
		send_byte(token_m);
		send_byte(8'hA5);
		send_frame(16'd2, SEQ_RESTART, 1'b1, 1'b0);
	endtask

	// A header at the largest length must pass the length check; the bad token ends it.
	task automatic test_length_limits();
		send_frame(16'd0, SEQ_RESTART, 1'b0, 1'b0);
		send_frame(16'(MAX_LEN + 1), SEQ_RESTART, 1'b0, 1'b0);
		send_frame(16'hFFFF, SEQ_KEEP, 1'b0, 1'b0);
		send_frame(16'(MAX_LEN), SEQ_RESTART, 1'b1, 1'b0);
	endtask

	// After a bad checksum the frame's sequence number stays the expected one.
	task automatic test_checksum();
		send_frame(16'd1, SEQ_KEEP, 1'b0, 1'b0);
		send_frame(16'd3, SEQ_KEEP, 1'b0, 1'b1);
		send_frame(16'd1, SEQ_KEEP, 1'b0, 1'b0);
	endtask

	task automatic test_register_extremes();
		set_config(8'h00, 8'hFF);
		random_frame();
		set_config(8'hFF, 8'h00);
		random_frame();
		set_config(8'h5A, 8'h5A);
		random_frame();
		set_config(sfr_pkg::START_BYTE_RST, sfr_pkg::TOKEN_BYTE_RST);
	endtask

	// Walk the sequence number through its wrap, the first frames with no idling.
	task automatic test_sequence_wrap();
		int n;
		n = 0;
		steady = 1'b1;
		do begin
			send_frame(16'd1, SEQ_KEEP, 1'b0, 1'b0);
			n++;
			if (n == STEADY_FRAMES)
				steady = 1'b0;
		end while (exp_seq != 8'd0);
		steady = 1'b0;
		send_frame(16'd1, SEQ_KEEP, 1'b0, 1'b0);
	endtask

	task automatic test_backpressure();
		steady = 1'b1;
		hold_asked++;
		send_frame(16'd48, SEQ_KEEP, 1'b0, 1'b0);
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		int base;
		int frames;
		base = parsed_bytes;
		frames = 0;
		while (parsed_bytes - base < RANDOM_ITEMS) begin
			random_frame();
			frames++;
			if (frames % 2 == 0)
				set_config(reg_pick(), reg_pick());
		end
	endtask

	// Result consumer: long hold-off on request, otherwise random stalls.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_asked) begin
			out_ready  <= 1'b0;
			hold_left  <= HOLD_CYCLES;
			hold_taken <= hold_taken + 1;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 17);
		end
	end

	always @(posedge clk) begin
		frame_event_t want;
		if (arst_n && out_valid && out_ready) begin
			seen_kind[event_kind]++;
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("unexpected word, kind %0d", event_kind));
			end else begin
				want = pending_events.pop_front();
				if (event_kind !== want.kind)
					report_mismatch($sformatf("event_kind %0d, expected %0d",
						event_kind, want.kind));
				if (payload_byte !== want.pbyte)
					report_mismatch($sformatf("payload_byte %0h, expected %0h",
						payload_byte, want.pbyte));
				if (payload_index !== want.pindex)
					report_mismatch($sformatf("payload_index %0d, expected %0d",
						payload_index, want.pindex));
				if (frame_seq !== want.seq)
					report_mismatch($sformatf("frame_seq %0d, expected %0d",
						frame_seq, want.seq));
				if (frame_length !== want.length)
					report_mismatch($sformatf("frame_length %0d, expected %0d",
						frame_length, want.length));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", quiet_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_header_rejects();
		test_length_limits();
		test_checksum();
		test_register_extremes();
		test_sequence_wrap();
		test_backpressure();
		test_random_traffic();
		drain();
		if (pending_events.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", pending_events.size()));
		$display("parsed %0d frame bytes: %0d payload, %0d good, %0d bad, %0d length errors",
			parsed_bytes, seen_kind[sfr_pkg::EV_PAYLOAD], seen_kind[sfr_pkg::EV_GOOD],
			seen_kind[sfr_pkg::EV_BAD], seen_kind[sfr_pkg::EV_LENERR]);
		$display("%0d register writes, length bounds, sequence wrap, %0d-cycle output stall",
			reg_writes, HOLD_CYCLES);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_parser.sv
hw/rtl/serial_frame_receiver_core.sv
tb/serial_frame_receiver_core_tb.sv
